[src/tbwp_pkg.sv]
// Package for the tile background/window pixel pipeline.
// Screen geometry, opcodes, register indexes, memory layout and stage types.
// No dependencies.
package tbwp_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 144;

  // Video memory layout
  localparam int VMEM_AW     = 13;
  localparam int MAP_DEPTH   = 2048;              // tile maps at 0x1800..0x1FFF
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int BANK_DEPTH  = 4096;              // even / odd byte banks
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam logic [1:0] MAP_REGION = 2'b11;      // address bits 12:11 of the maps

  // Signed tile addressing: 0x1000 + sext(idx) * 16 == 0x0800 + (idx ^ 0x80) * 16
  localparam logic [VMEM_AW-1:0] TILE_SIGNED_BASE = 13'h0800;
  localparam logic [7:0]         IDX_SIGN_FLIP    = 8'h80;

  // Window left edge offset
  localparam logic [8:0] WIN_X_OFFSET = 9'd7;

  // Input opcodes
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } opcode_t;

  // Configuration register indexes
  localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
  localparam logic [2:0] REG_SCROLL_X    = 3'd1;
  localparam logic [2:0] REG_SCROLL_Y    = 3'd2;
  localparam logic [2:0] REG_WIN_XPOS    = 3'd3;
  localparam logic [2:0] REG_WIN_YPOS    = 3'd4;

  // lcd_control bit positions
  localparam int LCDC_BG_ON    = 0;
  localparam int LCDC_BG_MAP   = 3;
  localparam int LCDC_TILE_UNS = 4;
  localparam int LCDC_WIN_ON   = 5;
  localparam int LCDC_WIN_MAP  = 6;

  // Stage payloads
  typedef struct packed {
    logic [7:0] line;
    logic [7:0] column;
  } s1_t;

  typedef struct packed {
    logic [7:0] line;
    logic [7:0] column;
    logic       drawn;
    logic       from_window;
    logic [2:0] px;
    logic [2:0] py;
  } s2_t;

  typedef struct packed {
    logic [7:0] line;
    logic [7:0] column;
    logic       drawn;
    logic       from_window;
    logic [2:0] px;
  } s3_t;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] line;
    logic       from_window;
    logic       drawn;
    logic [1:0] shade;
  } result_t;

endpackage

[src/tbwp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write; read data holds while re is low.
// No dependencies.
module tbwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage and registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

[src/tile_background_window_pixel.sv]
// Top level of the tile background/window pixel pipeline.
// Uses tbwp_pkg and three tbwp_ram instances (tile maps, even and odd tile bytes).
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in_      | in_tvalid / in_tready | tuser: opcode; tdata: address, data,
//           |                       |   line, column
//  out_     | out_tvalid/out_tready | tdata: shade, drawn, from_window, line,
//           |                       |   column
//  cfg_     | cfg_valid / cfg_ready | cfg_addr: register index; cfg_data: value
//
// One transaction per cycle is accepted unless out_ stalls; a render transaction
// passes stage 1, stage 2 (map read), stage 3 (tile byte read) and output register.
// The map and tile byte RAM ports are each read once per cycle, which sets that rate.
// A write transaction reaches video memory at the next advancing edge, in step with
// stage 1, so it never overtakes the reads of an earlier render; it yields no result.
// A low out_tready with a result waiting freezes every stage and drops in_tready.
// Reset clears valids and configuration registers; video memory is not cleared.
module tile_background_window_pixel (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] opcode
  input  logic [39:0] in_tdata,   // [12:0] mem_address, [20:13] mem_data,
                                  // [28:21] screen_line, [36:29] screen_column
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] shade, [2] drawn, [3] from_window,
                                  // [11:4] line_out, [19:12] column_out
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_data
);

  // Configuration registers
  logic [7:0] lcd_control_r, scroll_x_r, scroll_y_r, win_xpos_r, win_ypos_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_control_r <= '0;
      scroll_x_r    <= '0;
      scroll_y_r    <= '0;
      win_xpos_r    <= '0;
      win_ypos_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        tbwp_pkg::REG_LCD_CONTROL: lcd_control_r <= cfg_data;
        tbwp_pkg::REG_SCROLL_X:    scroll_x_r    <= cfg_data;
        tbwp_pkg::REG_SCROLL_Y:    scroll_y_r    <= cfg_data;
        tbwp_pkg::REG_WIN_XPOS:    win_xpos_r    <= cfg_data;
        tbwp_pkg::REG_WIN_YPOS:    win_ypos_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global pipeline advance: everything moves unless a result is stuck
  logic advance;
  logic out_valid_r;
  logic in_accept;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;
  assign in_accept = in_tvalid && in_tready;

  // Input unpacking
  tbwp_pkg::opcode_t      in_op;
  logic [tbwp_pkg::VMEM_AW-1:0] in_addr;
  logic [7:0]             in_data;
  logic [7:0]             in_line;
  logic [7:0]             in_column;

  assign in_op     = tbwp_pkg::opcode_t'(in_tuser[0]);
  assign in_addr   = in_tdata[12:0];
  assign in_data   = in_tdata[20:13];
  assign in_line   = in_tdata[28:21];
  assign in_column = in_tdata[36:29];

  // Video memory write, held one stage so it lands in order with the reads
  logic                         wr_valid_r;
  logic [tbwp_pkg::VMEM_AW-1:0] wr_addr_r;
  logic [7:0]                   wr_data_r;
  logic wr_en, map_we, even_we, odd_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else if (advance) begin
      wr_valid_r <= in_accept && (in_op == tbwp_pkg::OP_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wr_addr_r <= in_addr;
      wr_data_r <= in_data;
    end
  end

  assign wr_en   = advance && wr_valid_r;
  assign map_we  = wr_en && (wr_addr_r[12:11] == tbwp_pkg::MAP_REGION);
  assign even_we = wr_en && !wr_addr_r[0];
  assign odd_we  = wr_en && wr_addr_r[0];

  // Stage 1: capture the render transaction
  logic          s1_valid_r;
  tbwp_pkg::s1_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_accept && (in_op == tbwp_pkg::OP_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r.line   <= in_line;
      s1_r.column <= in_column;
    end
  end

  // Stage 1 logic: visibility, scroll / window offset, map address
  logic [8:0] line9, col9, col_p7, wx;
  logic [7:0] wy, bx, by;
  logic       on_screen, win_vis, use_win;
  logic [tbwp_pkg::MAP_AW-1:0] map_raddr;
  tbwp_pkg::s2_t s2_nxt;

  always_comb begin
    line9     = {1'b0, s1_r.line};
    col9      = {1'b0, s1_r.column};
    col_p7    = col9 + tbwp_pkg::WIN_X_OFFSET;
    on_screen = lcd_control_r[tbwp_pkg::LCDC_BG_ON] &&
                (line9 < 9'(tbwp_pkg::SCREEN_HEIGHT)) &&
                (col9 < 9'(tbwp_pkg::SCREEN_WIDTH));
    // left edge (xpos - 7) below width, as xpos < width + 7
    win_vis   = lcd_control_r[tbwp_pkg::LCDC_WIN_ON] &&
                (s1_r.line >= win_ypos_r) &&
                ({1'b0, win_xpos_r} < (9'(tbwp_pkg::SCREEN_WIDTH) + tbwp_pkg::WIN_X_OFFSET));
    use_win   = win_vis && (col_p7 >= {1'b0, win_xpos_r});
    wx        = col_p7 - {1'b0, win_xpos_r};
    wy        = s1_r.line - win_ypos_r;
    bx        = s1_r.column + scroll_x_r;
    by        = s1_r.line + scroll_y_r;

    if (use_win) begin
      map_raddr = {lcd_control_r[tbwp_pkg::LCDC_WIN_MAP], wy[7:3], wx[7:3]};
      s2_nxt.px = wx[2:0];
      s2_nxt.py = wy[2:0];
    end else begin
      map_raddr = {lcd_control_r[tbwp_pkg::LCDC_BG_MAP], by[7:3], bx[7:3]};
      s2_nxt.px = bx[2:0];
      s2_nxt.py = by[2:0];
    end
    s2_nxt.line        = s1_r.line;
    s2_nxt.column      = s1_r.column;
    s2_nxt.drawn       = on_screen;
    s2_nxt.from_window = on_screen && use_win;
  end

  // Tile map RAM (read in stage 1, data in stage 2)
  logic [7:0] map_rdata;

  tbwp_ram #(
    .WIDTH (8),
    .DEPTH (tbwp_pkg::MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (wr_addr_r[tbwp_pkg::MAP_AW-1:0]),
    .wdata (wr_data_r),
    .re    (advance),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Stage 2 registers
  logic          s2_valid_r;
  tbwp_pkg::s2_t s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 2 logic: tile row address from the map entry
  logic [tbwp_pkg::VMEM_AW-1:0] tile_base, tile_addr;
  logic [tbwp_pkg::BANK_AW-1:0] bank_raddr;
  tbwp_pkg::s3_t s3_nxt;

  always_comb begin
    if (lcd_control_r[tbwp_pkg::LCDC_TILE_UNS]) begin
      tile_base = {1'b0, map_rdata, 4'b0000};
    end else begin
      tile_base = tbwp_pkg::TILE_SIGNED_BASE +
                  {1'b0, map_rdata ^ tbwp_pkg::IDX_SIGN_FLIP, 4'b0000};
    end
    // low nibble of the base is zero, so the row offset just fills it
    tile_addr  = tile_base | {9'b0, s2_r.py, 1'b0};
    bank_raddr = tile_addr[tbwp_pkg::VMEM_AW-1:1];

    s3_nxt.line        = s2_r.line;
    s3_nxt.column      = s2_r.column;
    s3_nxt.drawn       = s2_r.drawn;
    s3_nxt.from_window = s2_r.from_window;
    s3_nxt.px          = s2_r.px;
  end

  // Tile byte banks: low plane at even, high plane at odd addresses
  logic [7:0] lo_rdata, hi_rdata;

  tbwp_ram #(
    .WIDTH (8),
    .DEPTH (tbwp_pkg::BANK_DEPTH)
  ) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (wr_addr_r[tbwp_pkg::VMEM_AW-1:1]),
    .wdata (wr_data_r),
    .re    (advance),
    .raddr (bank_raddr),
    .rdata (lo_rdata)
  );

  tbwp_ram #(
    .WIDTH (8),
    .DEPTH (tbwp_pkg::BANK_DEPTH)
  ) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (wr_addr_r[tbwp_pkg::VMEM_AW-1:1]),
    .wdata (wr_data_r),
    .re    (advance),
    .raddr (bank_raddr),
    .rdata (hi_rdata)
  );

  // Stage 3 registers
  logic          s3_valid_r;
  tbwp_pkg::s3_t s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 3 logic: pick the pixel bit, leftmost pixel is bit 7
  logic [2:0]        bit_sel;
  tbwp_pkg::result_t out_nxt;

  always_comb begin
    bit_sel             = ~s3_r.px;
    out_nxt.shade       = s3_r.drawn ? {hi_rdata[bit_sel], lo_rdata[bit_sel]} : 2'b00;
    out_nxt.drawn       = s3_r.drawn;
    out_nxt.from_window = s3_r.from_window;
    out_nxt.line        = s3_r.line;
    out_nxt.column      = s3_r.column;
  end

  // Output register
  tbwp_pkg::result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r};

endmodule

[src/tbwp_checker.sv]
// Port-level checker for tile_background_window_pixel, attached by bind.
// Uses tbwp_pkg for the screen width.
module tbwp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Input is open whenever no result waits
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A skipped pixel carries no shade and no window flag
  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> (out_tdata[1:0] == 2'b00) && !out_tdata[3])
    else $error("skipped pixel has shade or window flag");

  // A drawn pixel lies on the screen
  a_drawn_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> ({1'b0, out_tdata[19:12]} < 9'(tbwp_pkg::SCREEN_WIDTH)))
    else $error("drawn pixel beyond screen width");

endmodule

bind tile_background_window_pixel tbwp_checker u_tbwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
